FILE: rtl/core/lps_pkg.sv
// lps_pkg: shared types and constants for the line pattern search core
// used by every module under rtl/core; no dependencies

package lps_pkg;

    // widest pattern the core can be built for
    localparam int PATTERN_MAX_DEF = 16;
    localparam int PAT_BYTES       = 16;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MODE    = 2'd0,
        REG_LENGTH  = 2'd1,
        REG_PAT_LO  = 2'd2,
        REG_PAT_HI  = 2'd3
    } t_reg_index;

    // search modes; code 3 never reports
    typedef enum logic [1:0] {
        MODE_FIRST = 2'd0,
        MODE_ALL   = 2'd1,
        MODE_COUNT = 2'd2
    } t_search_mode;

    typedef enum logic [1:0] {
        RPT_MATCH     = 2'd0,
        RPT_NOT_FOUND = 2'd1,
        RPT_COUNT     = 2'd2
    } t_report_type;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  length;
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
    } t_cfg;

    // current line status handed from the window to the report logic
    typedef struct packed {
        logic hit;
        logic nonempty;
    } t_line_stat;

endpackage

FILE: rtl/core/line_pattern_search_core.sv
// Line pattern search core: takes one text word per cycle and checks each
// newline-terminated line for a configured pattern of up to PATTERN_MAX bytes,
// reporting matching line numbers, not found, or the match count at end of
// stream. Rate is one word per clock: the window compare and counter update
// finish in the cycle of acceptance and a report appears in the result
// register on the next cycle. The input stalls only when a word would report
// while an earlier report is still held in the result register.
// Configuration is written through a separate index/data port, always ready.
// Depends on lps_pkg, lps_cfg_regs, lps_window, lps_report.

module line_pattern_search_core #(
    parameter int PATTERN_MAX = lps_pkg::PATTERN_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_kind,
    input  logic [7:0]            i_text_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output lps_pkg::t_report_type o_report_type,
    output logic [31:0]           o_report_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [63:0]           i_cfg_data
);
    import lps_pkg::*;

    t_cfg       cfg;
    t_line_stat stat;
    logic       fire;
    logic       accept;

    assign o_stall = o_valid && i_stall && fire;
    assign accept  = i_valid && !o_stall;

    lps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    lps_window #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_kind      (i_kind),
        .i_text_byte (i_text_byte),
        .i_cfg       (cfg),
        .o_stat      (stat)
    );

    lps_report u_report (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_kind         (i_kind),
        .i_text_byte    (i_text_byte),
        .i_cfg          (cfg),
        .i_stat         (stat),
        .i_out_stall    (i_stall),
        .o_fire         (fire),
        .o_valid        (o_valid),
        .o_report_type  (o_report_type),
        .o_report_value (o_report_value)
    );

endmodule

FILE: rtl/core/lps_cfg_regs.sv
// lps_cfg_regs: configuration register file of the line pattern search core
// depends on lps_pkg

module lps_cfg_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    output logic                  o_cfg_ready,
    output lps_pkg::t_cfg         o_cfg
);
    import lps_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_FIRST;
            r_cfg.length <= 5'd1;
            r_cfg.pat_lo <= '0;
            r_cfg.pat_hi <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:   r_cfg.mode   <= i_cfg_data[1:0];
                REG_LENGTH: r_cfg.length <= i_cfg_data[4:0];
                REG_PAT_LO: r_cfg.pat_lo <= i_cfg_data;
                REG_PAT_HI: r_cfg.pat_hi <= i_cfg_data;
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

endmodule

FILE: rtl/core/lps_window.sv
// lps_window: recent byte window of the current line, fill count and line hit flag
// depends on lps_pkg

module lps_window #(
    parameter int PATTERN_MAX = lps_pkg::PATTERN_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_kind,
    input  logic [7:0]            i_text_byte,
    input  lps_pkg::t_cfg         i_cfg,
    output lps_pkg::t_line_stat   o_stat
);
    import lps_pkg::*;

    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(PATTERN_MAX);
    localparam logic [4:0]    LEN_MAX = 5'(PATTERN_MAX);

    logic [7:0]    r_win [PATTERN_MAX];
    logic [7:0]    n_win [PATTERN_MAX];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_hit;
    logic [7:0]    pat [PATTERN_MAX];
    logic [4:0]    used_len;
    logic [4:0]    idx;
    logic          win_match;
    logic          is_text;

    assign is_text = !i_kind && (i_text_byte != CHAR_NEWLINE);

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (k < 8) begin
                pat[k] = i_cfg.pat_lo[8*k +: 8];
            end else begin
                pat[k] = i_cfg.pat_hi[8*(k-8) +: 8];
            end
        end
    end

    // window after the incoming byte is shifted in, newest at index 0
    always_comb begin
        n_win[0] = i_text_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            n_win[j] = r_win[j-1];
        end
        n_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    end

    always_comb begin
        used_len  = (i_cfg.length > LEN_MAX) ? LEN_MAX : i_cfg.length;
        win_match = (5'(n_cnt) >= used_len);
        idx       = '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (5'(k) < used_len) begin
                // pattern byte k lines up with the byte n-1-k places back
                idx = used_len - 5'd1 - 5'(k);
                if (n_win[idx[IW-1:0]] != pat[k]) begin
                    win_match = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && is_text) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win[j] <= n_win[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_hit <= 1'b0;
        end else if (i_accept) begin
            if (is_text) begin
                r_cnt <= n_cnt;
                r_hit <= r_hit | win_match;
            end else begin
                r_cnt <= '0;
                r_hit <= 1'b0;
            end
        end
    end

    assign o_stat.hit      = r_hit;
    assign o_stat.nonempty = (r_cnt != '0);

endmodule

FILE: rtl/core/lps_report.sv
// lps_report: line and match counters, report decision and result register
// depends on lps_pkg

module lps_report (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_kind,
    input  logic [7:0]            i_text_byte,
    input  lps_pkg::t_cfg         i_cfg,
    input  lps_pkg::t_line_stat   i_stat,
    input  logic                  i_out_stall,
    output logic                  o_fire,
    output logic                  o_valid,
    output lps_pkg::t_report_type o_report_type,
    output logic [31:0]           o_report_value
);
    import lps_pkg::*;

    logic [31:0]  r_line;
    logic [31:0]  r_total;
    logic         r_done;
    logic         r_valid;
    t_report_type r_type;
    logic [31:0]  r_value;

    logic [31:0]  n_line;
    logic [31:0]  n_total;
    logic         n_done;
    t_report_type n_type;
    logic [31:0]  n_value;
    logic         is_end;
    logic         do_finish;
    logic         hit;
    logic         fin_rep;

    always_comb begin
        is_end    = i_kind;
        do_finish = (!i_kind && i_text_byte == CHAR_NEWLINE) || (i_kind && i_stat.nonempty);
        hit       = i_stat.hit || (i_cfg.length == 5'd0);
        n_total   = r_total;
        if (do_finish && hit && (r_total != '1)) begin
            n_total = r_total + 32'd1;
        end
        fin_rep = do_finish && hit &&
                  ((i_cfg.mode == MODE_FIRST && !r_done) || i_cfg.mode == MODE_ALL);

        o_fire  = 1'b0;
        n_type  = RPT_MATCH;
        n_value = r_line;
        if (fin_rep) begin
            o_fire = 1'b1;
        end else if (is_end) begin
            if (i_cfg.mode == MODE_COUNT) begin
                o_fire  = 1'b1;
                n_type  = RPT_COUNT;
                n_value = n_total;
            end else if ((i_cfg.mode == MODE_FIRST || i_cfg.mode == MODE_ALL) &&
                         n_total == '0) begin
                o_fire  = 1'b1;
                n_type  = RPT_NOT_FOUND;
                n_value = '0;
            end
        end

        // end of stream starts a fresh stream
        n_line = r_line;
        n_done = r_done;
        if (is_end) begin
            n_line  = 32'd1;
            n_total = '0;
            n_done  = 1'b0;
        end else if (do_finish) begin
            if (r_line != '1) begin
                n_line = r_line + 32'd1;
            end
            n_done = r_done | (hit && i_cfg.mode == MODE_FIRST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= 32'd1;
            r_total <= '0;
            r_done  <= 1'b0;
        end else if (i_accept) begin
            r_line  <= n_line;
            r_total <= n_total;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept && o_fire) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && o_fire) begin
            r_type  <= n_type;
            r_value <= n_value;
        end
    end

    assign o_valid        = r_valid;
    assign o_report_type  = r_type;
    assign o_report_value = r_value;

endmodule

FILE: bench/testbench.sv
// testbench for line_pattern_search_core: directed and random text streams checked
// against an in-bench line search predictor; depends on lps_pkg and the core rtl
`timescale 1ns / 100ps

module testbench;
    import lps_pkg::*;

    localparam int PAT_MAX        = PATTERN_MAX_DEF;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_SLACK      = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 150;
    localparam int RAND_PHASES    = 13;
    localparam logic [1:0] MODE_UNDEF = 2'd3;

    typedef struct {
        bit         is_end;
        logic [7:0] byte_val;
    } t_text_word;

    typedef struct {
        t_report_type kind;
        logic [31:0]  value;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_kind = 1'b0;
    logic [7:0]  i_text_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = REG_MODE;
    logic [63:0] i_cfg_data = 64'd0;
    logic        o_stall;
    logic        o_valid;
    logic        o_cfg_ready;
    t_report_type o_report_type;
    logic [31:0] o_report_value;

    line_pattern_search_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_text_byte    (i_text_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_report_type  (o_report_type),
        .o_report_value (o_report_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor copy of the registers and the search state
    logic [1:0]   cfg_mode;
    logic [4:0]   cfg_len;
    logic [63:0]  cfg_pat_lo;
    logic [63:0]  cfg_pat_hi;
    logic [7:0]   window [PAT_MAX];
    int unsigned  line_fill;
    bit           line_hit;
    logic [31:0]  line_no;
    logic [31:0]  hit_total;
    bit           first_done;

    t_text_word   text_words_q [$];
    t_report      reports_due [$];
    t_text_word   cur_word;
    int           err_count = 0;
    int           words_sent = 0;
    int           streams_ended = 0;
    int           reports_checked = 0;
    int           settings_used = 0;
    int           gap_left = 0;
    int           stall_left = 0;
    bit           quiet = 1'b0;

    function automatic int eff_len();
        return (cfg_len > PAT_MAX) ? PAT_MAX : int'(cfg_len);
    endfunction

    function automatic bit window_hit();
        int n;
        logic [127:0] pat;
        n = eff_len();
        pat = {cfg_pat_hi, cfg_pat_lo};
        if (n == 0) return 1'b1;
        if (line_fill < n) return 1'b0;
        // window[0] holds the newest byte, so pattern byte 0 sits n-1 back
        for (int k = 0; k < n; k++) begin
            if (window[n - 1 - k] != pat[8*k +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_line();
        for (int k = 0; k < PAT_MAX; k++) window[k] = 8'h00;
        line_fill = 0;
        line_hit = 1'b0;
    endtask

    task automatic clear_stream();
        clear_line();
        line_no = 32'd1;
        hit_total = 32'd0;
        first_done = 1'b0;
    endtask

    task automatic close_line(output bit made, output t_report rpt);
        made = 1'b0;
        rpt = '{RPT_MATCH, 32'd0};
        if (line_hit || eff_len() == 0) begin
            if (hit_total != 32'hFFFF_FFFF) hit_total++;
            if (cfg_mode == MODE_FIRST && !first_done) begin
                rpt = '{RPT_MATCH, line_no};
                first_done = 1'b1;
                made = 1'b1;
            end else if (cfg_mode == MODE_ALL) begin
                rpt = '{RPT_MATCH, line_no};
                made = 1'b1;
            end
        end
        if (line_no != 32'hFFFF_FFFF) line_no++;
        clear_line();
    endtask

    task automatic scan_word(input t_text_word w);
        bit made;
        t_report rpt;
        made = 1'b0;
        if (!w.is_end) begin
            if (w.byte_val == CHAR_NEWLINE) begin
                close_line(made, rpt);
            end else begin
                for (int k = PAT_MAX - 1; k > 0; k--) window[k] = window[k - 1];
                window[0] = w.byte_val;
                if (line_fill < PAT_MAX) line_fill++;
                if (window_hit()) line_hit = 1'b1;
            end
        end else begin
            // an unterminated last line still counts as a line
            if (line_fill > 0) close_line(made, rpt);
            if (!made) begin
                if (cfg_mode == MODE_COUNT) begin
                    rpt = '{RPT_COUNT, hit_total};
                    made = 1'b1;
                end else if ((cfg_mode == MODE_FIRST || cfg_mode == MODE_ALL)
                             && hit_total == 0) begin
                    rpt = '{RPT_NOT_FOUND, 32'd0};
                    made = 1'b1;
                end
            end
            clear_stream();
        end
        if (made) reports_due.push_back(rpt);
    endtask

    // sender: one word per handshake, random gaps only between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                scan_word(cur_word);
                words_sent++;
                if (cur_word.is_end) streams_ended++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(1, 13) - 1;
                    i_valid <= 1'b0;
                end else if (text_words_q.size() > 0) begin
                    cur_word = text_words_q.pop_front();
                    i_valid <= 1'b1;
                    i_kind <= cur_word.is_end;
                    i_text_byte <= cur_word.byte_val;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall bursts and in-order report checks
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (reports_due.size() == 0) begin
                    $display("%0t unexpected report: expected none, actual type %0d value %0d",
                             $time, o_report_type, o_report_value);
                    err_count++;
                end else begin
                    t_report want;
                    want = reports_due.pop_front();
                    reports_checked++;
                    if (o_report_type != want.kind) begin
                        $display("%0t report type mismatch: expected %0d, actual %0d",
                                 $time, want.kind, o_report_type);
                        err_count++;
                    end
                    if (o_report_value != want.value) begin
                        $display("%0t report value mismatch: expected %0d, actual %0d",
                                 $time, want.value, o_report_value);
                        err_count++;
                    end
                end
            end
            if (quiet) begin
                i_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("%0t no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** line_pattern_search_core: FAILED **");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        text_words_q.push_back('{1'b0, b});
    endtask

    task automatic push_end();
        text_words_q.push_back('{1'b1, 8'($urandom)});
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) push_byte(s[k]);
    endtask

    task automatic wait_drained();
        while (!(text_words_q.size() == 0 && !i_valid && reports_due.size() == 0))
            @(negedge i_clk);
        // words that cause no report may still be inside the core
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_MODE:   cfg_mode = val[1:0];
            REG_LENGTH: cfg_len = val[4:0];
            REG_PAT_LO: cfg_pat_lo = val;
            REG_PAT_HI: cfg_pat_hi = val;
            default: ;
        endcase
    endtask

    task automatic set_search(input logic [1:0] mode, input logic [4:0] len,
                              input logic [127:0] pat);
        wait_drained();
        // upper data bits above the field are noise the core must drop
        write_reg(REG_MODE, {30'($urandom), 32'($urandom), mode} );
        write_reg(REG_LENGTH, {27'($urandom), 32'($urandom), len});
        write_reg(REG_PAT_LO, pat[63:0]);
        write_reg(REG_PAT_HI, pat[127:64]);
        settings_used++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] filler(input logic [127:0] pat, input int n);
        logic [7:0] b;
        if (n > 0 && $urandom_range(0, 1) == 1) return pat[8*$urandom_range(0, n - 1) +: 8];
        b = 8'($urandom);
        if (b == CHAR_NEWLINE) b = "a";
        return b;
    endfunction

    task automatic fill_random_phase(input logic [127:0] pat, input int n, input int budget);
        int added, r, pick, bad;
        logic [7:0] b;
        added = 0;
        while (added < budget) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                repeat ($urandom_range(1, 4)) begin
                    push_byte(8'($urandom));
                    added++;
                end
            end else if (r < 14) begin
                push_end();
                added++;
            end else begin
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 5)) begin
                    push_byte(filler(pat, n));
                    added++;
                end
                pick = $urandom_range(0, 99);
                bad = (n > 0) ? $urandom_range(0, n - 1) : 0;
                if (pick < 65) begin
                    // full pattern, or a near miss with one byte changed
                    for (int k = 0; k < n; k++) begin
                        b = pat[8*k +: 8];
                        if (pick >= 45 && k == bad) b = b ^ 8'($urandom_range(1, 255));
                        push_byte(b);
                        added++;
                    end
                end
                repeat ($urandom_range(0, 4)) begin
                    push_byte(filler(pat, n));
                    added++;
                end
                if ($urandom_range(0, 11) != 0) begin
                    push_byte(CHAR_NEWLINE);
                    added++;
                end
            end
        end
    endtask

    initial begin
        logic [1:0]   mode;
        logic [4:0]   len;
        logic [127:0] pat;
        int           n;

        cfg_mode = MODE_FIRST;
        cfg_len = 5'd1;
        cfg_pat_lo = 64'd0;
        cfg_pat_hi = 64'd0;
        clear_stream();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: first mode, one-byte pattern of zero
        push_byte(8'h00);
        push_byte(CHAR_NEWLINE);
        push_byte(8'hFF);
        push_byte(CHAR_NEWLINE);
        push_end();

        // every matching line, unterminated last line with and without a hit
        set_search(MODE_ALL, 5'd3, {64'hFFFF_FFFF_FFFF_FFFF, 40'd0, "caf"});
        push_text("fac\na");
        push_end();
        push_text("fac");
        push_end();

        // empty pattern matches the empty line
        set_search(MODE_COUNT, 5'd0, 128'd0);
        push_byte(CHAR_NEWLINE);
        push_end();

        // a newline in the pattern never matches
        set_search(MODE_FIRST, 5'd1, {64'd0, 56'd0, CHAR_NEWLINE});
        push_byte(CHAR_NEWLINE);
        push_end();

        // undefined mode, length above the maximum
        set_search(MODE_UNDEF, 5'd20, {"abcdefgh", "ijklmnop"});
        push_text("ab\n");
        push_end();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:  begin mode = MODE_FIRST; len = 5'd1;  end
                1:  begin mode = MODE_ALL;   len = 5'd16; end
                2:  begin mode = MODE_COUNT; len = 5'd4;  end
                3:  begin mode = MODE_ALL;   len = 5'd0;  end
                4:  begin mode = MODE_FIRST; len = 5'd8;  end
                5:  begin mode = MODE_COUNT; len = 5'd16; end
                6:  begin mode = MODE_UNDEF; len = 5'd5;  end
                7:  begin mode = MODE_ALL;   len = 5'd31; end
                8:  begin mode = MODE_COUNT; len = 5'd1;  end
                9:  begin mode = MODE_FIRST; len = 5'd17; end
                10: begin mode = MODE_ALL;   len = 5'd2;  end
                11: begin mode = MODE_COUNT; len = 5'd9;  end
                default: begin mode = MODE_ALL; len = 5'd16; end
            endcase
            pat = {$urandom, $urandom, $urandom, $urandom};
            if (p == 1) pat = '1;
            if (p == 8) pat = '0;
            // keep newlines out of most patterns so lines can match
            if (p != 6) begin
                for (int k = 0; k < PAT_BYTES; k++)
                    if (pat[8*k +: 8] == CHAR_NEWLINE) pat[8*k +: 8] = 8'h0B;
            end
            set_search(mode, len, pat);
            if (p == RAND_PHASES - 1) quiet = 1'b1;
            n = (len > PAT_MAX) ? PAT_MAX : int'(len);
            fill_random_phase(pat, n, PHASE_WORDS);
            if (p == RAND_PHASES - 1) push_end();
        end

        wait_drained();
        repeat (END_SLACK) @(negedge i_clk);
        if (reports_due.size() != 0) begin
            $display("%0t %0d expected reports never arrived", $time, reports_due.size());
            err_count++;
        end
        $display("covered %0d words in %0d streams under %0d register settings,",
                 words_sent, streams_ended, settings_used + 1);
        $display("%0d reports compared, %0d errors", reports_checked, err_count);
        if (err_count == 0) begin
            $display("** line_pattern_search_core: PASSED **");
        end else begin
            $display("** line_pattern_search_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/lps_pkg.sv
rtl/core/lps_cfg_regs.sv
rtl/core/lps_window.sv
rtl/core/lps_report.sv
rtl/core/line_pattern_search_core.sv
bench/testbench.sv
